/* src/rcbc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Chunk buffer cache package
// Shared sizes, codes and record types of the reference counted chunk cache.
// ----------------------------------------------------------------------------
package rcbc_pkg;

    localparam int NUM_BUFFERS   = 64;
    localparam int MAX_READAHEAD = 8;

    localparam int IDX_W   = $clog2(NUM_BUFFERS);
    localparam int CNT_W   = $clog2(NUM_BUFFERS + 1);
    localparam int SLOT_W  = 6;
    localparam int TOT_W   = 7;
    localparam int RES_DEPTH = MAX_READAHEAD + 2;
    localparam int RQ_IDX_W  = $clog2(RES_DEPTH);
    localparam int RQ_CNT_W  = $clog2(RES_DEPTH + 1);
    localparam int RA_W      = $clog2(MAX_READAHEAD + 2);

    localparam logic [1:0] FUNC_READ     = 2'd0;
    localparam logic [1:0] FUNC_COMPLETE = 2'd1;
    localparam logic [1:0] FUNC_BLANK    = 2'd2;
    localparam logic [1:0] FUNC_RELEASE  = 2'd3;

    localparam logic [1:0] REG_MOUNTED   = 2'd0;
    localparam logic [1:0] REG_VOL_SIZE  = 2'd1;
    localparam logic [1:0] REG_READAHEAD = 2'd2;

    localparam logic KIND_FETCH    = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_PENDING     = 3'd1;
    localparam logic [2:0] ST_NOT_MOUNTED = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR    = 3'd3;
    localparam logic [2:0] ST_NO_BUFFERS  = 3'd4;
    localparam logic [2:0] ST_FULL        = 3'd5;
    localparam logic [2:0] ST_IO_ERROR    = 3'd6;
    localparam logic [2:0] ST_BAD_RELEASE = 3'd7;

    typedef struct packed {
        logic [31:0] tag;
        logic [15:0] refs;
        logic        fetching;
        logic        bad;
        logic [31:0] age;
        logic [7:0]  waiters;
    } entry_t;

    typedef struct packed {
        logic              kind;
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       addr;
        logic [7:0]        waiters;
        logic              destroyed;
    } res_t;

    typedef struct packed {
        logic push;
        logic commit;
        res_t data;
    } rq_ctl_t;

endpackage
`default_nettype wire

/* src/rcbc_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rcbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/rcbc_resq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Collects the result beats of one request and sends them once it is done.
// ----------------------------------------------------------------------------
module rcbc_resq
    import rcbc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire rq_ctl_t ctl,
    input  wire logic    out_ready,
    output logic         out_valid,
    output res_t         out_res,
    output logic         out_last,
    output logic         idle
);

    res_t                buf_reg [RES_DEPTH];
    logic [RQ_CNT_W-1:0] cnt_reg;
    logic [RQ_IDX_W-1:0] rd_reg;
    logic                drain_reg;

    assign out_valid = drain_reg;
    assign out_res   = buf_reg[rd_reg];
    assign out_last  = (RQ_CNT_W'(rd_reg) + RQ_CNT_W'(1)) == cnt_reg;
    assign idle      = !drain_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            buf_reg[cnt_reg[RQ_IDX_W-1:0]] <= ctl.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            rd_reg    <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            if (ctl.push)
            begin
                cnt_reg <= cnt_reg + RQ_CNT_W'(1);
            end
            if (ctl.commit)
            begin
                drain_reg <= 1'b1;
            end
            if (drain_reg && out_ready)
            begin
                if (out_last)
                begin
                    drain_reg <= 1'b0;
                    cnt_reg   <= '0;
                    rd_reg    <= '0;
                end
                else
                begin
                    rd_reg <= rd_reg + RQ_IDX_W'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

/* src/refcounted_chunk_buffer_cache.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Reference counted chunk buffer cache
// Manages buffer entries that cache storage chunks: read, fetch completion,
// blank buffer and release requests, with read-ahead and oldest-first reuse.
//
// Requests arrive on the in channel (valid/ready), one beat per request.
// Each request yields one to ten result beats on the out channel: fetch
// commands for storage first, then the response, with last on the final beat.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Completions and releases read their entry and give one result beat; a blank
// request that finds a free entry claims that entry on acceptance. A read walks
// the entry memory once per lookup, and a blank request only when none is free;
// a walk reads one entry a cycle, and a read lookup stops at a hit. A new
// request is taken only after all beats of the previous one have gone out; a
// stalled receiver holds the block. Reset empties the cache at once and clears
// the control and configuration registers to zero.
// ----------------------------------------------------------------------------
module refcounted_chunk_buffer_cache
    import rcbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        func,
    input  wire logic [31:0]       addr,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic              io_error,
    input  wire logic              abort_waiter,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   kind,
    output logic [2:0]             status,
    output logic [SLOT_W-1:0]      slot_out,
    output logic [31:0]            addr_out,
    output logic [7:0]             waiter_count,
    output logic                   destroyed,
    output logic [TOT_W-1:0]       entries_in_use,
    output logic [TOT_W-1:0]       referenced_entries,
    output logic                   last
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_UPD, S_RA, S_FIN, S_SLOT} state_t;

    state_t state_reg, state_next;

    logic             mounted_reg;
    logic [31:0]      vsize_reg;
    logic [3:0]       ra_cnt_reg;

    logic [1:0]       func_reg, func_next;
    logic [31:0]      addr_reg, addr_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic             ioerr_reg, ioerr_next;
    logic             abort_reg, abort_next;

    logic [31:0]      key_reg, key_next;
    logic             lookup_reg, lookup_next;
    logic             ra_phase_reg, ra_phase_next;
    logic [RA_W-1:0]  ra_i_reg, ra_i_next;

    logic [IDX_W:0]   scan_idx_reg, scan_idx_next;
    logic             scan_pend_reg, scan_pend_next;
    logic [IDX_W-1:0] scan_ci_reg, scan_ci_next;
    logic             best_vld_reg, best_vld_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [31:0]      best_d_reg, best_d_next;

    logic [IDX_W-1:0] u_reg, u_next;
    entry_t           cur_reg, cur_next;

    logic [NUM_BUFFERS-1:0] used_reg, used_next;
    logic [NUM_BUFFERS-1:0] avail_reg, avail_next;
    logic [31:0]      age_reg, age_next;
    logic [CNT_W-1:0] used_tot_reg, used_tot_next;
    logic [CNT_W-1:0] ref_tot_reg, ref_tot_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    entry_t           ram_wdata, rent;
    logic [$bits(entry_t)-1:0] ram_rdata;

    rq_ctl_t          rq;
    res_t             out_res;
    logic             rq_idle;

    logic             has_free;
    logic [IDX_W-1:0] free_idx;
    logic             cand, take, vic_vld, hit, scan_done;
    logic [IDX_W-1:0] vic_idx, claim_idx;
    logic [31:0]      age_dist;

    rcbc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_BUFFERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rcbc_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rq),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_last  (last),
        .idle      (rq_idle)
    );

    assign kind               = out_res.kind;
    assign status             = out_res.status;
    assign slot_out           = out_res.slot;
    assign addr_out           = out_res.addr;
    assign waiter_count       = out_res.waiters;
    assign destroyed          = out_res.destroyed;
    assign entries_in_use     = TOT_W'(used_tot_reg);
    assign referenced_entries = TOT_W'(ref_tot_reg);

    assign in_ready = (state_reg == S_IDLE) && rq_idle;
    assign rent     = entry_t'(ram_rdata);

    always_comb
    begin
        free_idx = '0;
        for (int i = NUM_BUFFERS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign has_free  = !(&used_reg);
    assign cand      = scan_pend_reg && avail_reg[scan_ci_reg] && !rent.fetching;
    assign age_dist  = age_reg - rent.age;
    assign take      = cand && (!best_vld_reg || age_dist > best_d_reg);
    assign vic_vld   = best_vld_reg || cand;
    assign vic_idx   = take ? scan_ci_reg : best_idx_reg;
    assign hit       = scan_pend_reg && lookup_reg && used_reg[scan_ci_reg]
                       && rent.tag == key_reg && key_reg != 32'd0;
    assign scan_done = scan_pend_reg && (hit || scan_ci_reg == IDX_W'(NUM_BUFFERS - 1));
    assign claim_idx = has_free ? free_idx : vic_idx;

    always_comb
    begin
        entry_t      ent;
        logic        claim_go;
        logic        claim_blank;
        logic        finish;
        logic        slot_ok;
        logic [32:0] ra_sum;
        logic [31:0] ra_lim;

        state_next     = state_reg;
        func_next      = func_reg;
        addr_next      = addr_reg;
        slot_next      = slot_reg;
        ioerr_next     = ioerr_reg;
        abort_next     = abort_reg;
        key_next       = key_reg;
        lookup_next    = lookup_reg;
        ra_phase_next  = ra_phase_reg;
        ra_i_next      = ra_i_reg;
        scan_idx_next  = scan_idx_reg;
        scan_pend_next = scan_pend_reg;
        scan_ci_next   = scan_ci_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_d_next    = best_d_reg;
        u_next         = u_reg;
        cur_next       = cur_reg;
        used_next      = used_reg;
        avail_next     = avail_reg;
        age_next       = age_reg;
        used_tot_next  = used_tot_reg;
        ref_tot_next   = ref_tot_reg;
        ram_we         = 1'b0;
        ram_waddr      = u_reg;
        ram_wdata      = cur_reg;
        ram_raddr      = IDX_W'(slot);
        rq             = '0;
        ent            = cur_reg;
        claim_go       = 1'b0;
        claim_blank    = 1'b0;
        finish         = 1'b0;
        slot_ok        = 32'(slot_reg) < NUM_BUFFERS;
        ra_sum         = {1'b0, addr_reg} + 33'(ra_i_reg);
        ra_lim         = (32'(ra_cnt_reg) > MAX_READAHEAD) ? 32'(MAX_READAHEAD)
                                                           : 32'(ra_cnt_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    func_next      = func;
                    addr_next      = addr;
                    slot_next      = slot;
                    ioerr_next     = io_error;
                    abort_next     = abort_waiter;
                    key_next       = addr;
                    ra_phase_next  = 1'b0;
                    scan_idx_next  = '0;
                    scan_pend_next = 1'b0;
                    best_vld_next  = 1'b0;
                    unique case (func)
                        FUNC_READ:
                        begin
                            if (!mounted_reg)
                            begin
                                rq.push = 1'b1;
                                rq.data = '{KIND_RESPONSE, ST_NOT_MOUNTED, '0, addr, 8'd0, 1'b0};
                                finish  = 1'b1;
                            end
                            else if (addr == 32'd0 || addr > vsize_reg)
                            begin
                                rq.push = 1'b1;
                                rq.data = '{KIND_RESPONSE, ST_BAD_ADDR, '0, addr, 8'd0, 1'b0};
                                finish  = 1'b1;
                            end
                            else
                            begin
                                lookup_next = 1'b1;
                                state_next  = S_SCAN;
                            end
                        end
                        FUNC_BLANK:
                        begin
                            if (!mounted_reg)
                            begin
                                rq.push = 1'b1;
                                rq.data = '{KIND_RESPONSE, ST_NOT_MOUNTED, '0, 32'd0, 8'd0,
                                            1'b0};
                                finish  = 1'b1;
                            end
                            else if (has_free)
                            begin
                                claim_go    = 1'b1;
                                claim_blank = 1'b1;
                                finish      = 1'b1;
                            end
                            else
                            begin
                                lookup_next = 1'b0;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_SLOT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (scan_idx_reg < (IDX_W + 1)'(NUM_BUFFERS))
                begin
                    ram_raddr      = scan_idx_reg[IDX_W-1:0];
                    scan_pend_next = 1'b1;
                    scan_ci_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next  = scan_idx_reg + (IDX_W + 1)'(1);
                end
                else
                begin
                    scan_pend_next = 1'b0;
                end
                if (take)
                begin
                    best_vld_next = 1'b1;
                    best_idx_next = scan_ci_reg;
                    best_d_next   = age_dist;
                end
                if (scan_done)
                begin
                    if (func_reg == FUNC_BLANK)
                    begin
                        if (vic_vld)
                        begin
                            claim_go    = 1'b1;
                            claim_blank = 1'b1;
                        end
                        else
                        begin
                            rq.push = 1'b1;
                            rq.data = '{KIND_RESPONSE, ST_NO_BUFFERS, '0, 32'd0, 8'd0, 1'b0};
                        end
                        finish = 1'b1;
                    end
                    else if (hit)
                    begin
                        if (ra_phase_reg)
                        begin
                            state_next = S_RA;
                        end
                        else
                        begin
                            u_next     = scan_ci_reg;
                            cur_next   = rent;
                            state_next = S_UPD;
                        end
                    end
                    else if (has_free || vic_vld)
                    begin
                        claim_go = 1'b1;
                        if (ra_phase_reg)
                        begin
                            state_next = S_RA;
                        end
                        else
                        begin
                            u_next     = claim_idx;
                            cur_next   = '{key_reg, 16'd0, 1'b1, 1'b1, age_reg, 8'd0};
                            state_next = S_UPD;
                        end
                    end
                    else if (ra_phase_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rq.push = 1'b1;
                        rq.data = '{KIND_RESPONSE, ST_NO_BUFFERS, '0, addr_reg, 8'd0, 1'b0};
                        finish  = 1'b1;
                    end
                end
            end

            S_UPD:
            begin
                if (cur_reg.refs == 16'hFFFF)
                begin
                    rq.push = 1'b1;
                    rq.data = '{KIND_RESPONSE, ST_FULL, SLOT_W'(u_reg), addr_reg,
                                cur_reg.waiters, 1'b0};
                    finish  = 1'b1;
                end
                else
                begin
                    ent.refs = cur_reg.refs + 16'd1;
                    if (cur_reg.refs == 16'd0)
                    begin
                        avail_next[u_reg] = 1'b0;
                        ref_tot_next      = ref_tot_reg + CNT_W'(1);
                    end
                    ram_we     = 1'b1;
                    ram_wdata  = ent;
                    cur_next   = ent;
                    ra_i_next  = RA_W'(1);
                    state_next = S_RA;
                end
            end

            S_RA:
            begin
                if (32'(ra_i_reg) > ra_lim || ra_sum >= {1'b0, vsize_reg})
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    key_next       = ra_sum[31:0];
                    lookup_next    = 1'b1;
                    ra_phase_next  = 1'b1;
                    ra_i_next      = ra_i_reg + RA_W'(1);
                    scan_idx_next  = '0;
                    scan_pend_next = 1'b0;
                    best_vld_next  = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            S_FIN:
            begin
                rq.push = 1'b1;
                finish  = 1'b1;
                if (!cur_reg.fetching)
                begin
                    rq.data = '{KIND_RESPONSE, cur_reg.bad ? ST_IO_ERROR : ST_OK,
                                SLOT_W'(u_reg), addr_reg, cur_reg.waiters, 1'b0};
                end
                else if (cur_reg.waiters == 8'hFF)
                begin
                    ent.refs = cur_reg.refs - 16'd1;
                    if (cur_reg.refs == 16'd1)
                    begin
                        ref_tot_next      = ref_tot_reg - CNT_W'(1);
                        avail_next[u_reg] = 1'b1;
                        ent.age           = age_reg;
                        age_next          = age_reg + 32'd1;
                    end
                    ram_we    = 1'b1;
                    ram_wdata = ent;
                    rq.data   = '{KIND_RESPONSE, ST_FULL, SLOT_W'(u_reg), addr_reg,
                                  cur_reg.waiters, 1'b0};
                end
                else
                begin
                    ent.waiters = cur_reg.waiters + 8'd1;
                    ram_we      = 1'b1;
                    ram_wdata   = ent;
                    rq.data     = '{KIND_RESPONSE, ST_PENDING, SLOT_W'(u_reg), addr_reg,
                                    ent.waiters, 1'b0};
                end
            end

            S_SLOT:
            begin
                ent       = rent;
                ram_waddr = IDX_W'(slot_reg);
                rq.push   = 1'b1;
                finish    = 1'b1;
                if (func_reg == FUNC_COMPLETE)
                begin
                    if (!slot_ok || !used_reg[IDX_W'(slot_reg)] || !rent.fetching)
                    begin
                        rq.data = '{KIND_RESPONSE, ST_BAD_RELEASE, slot_reg, 32'd0, 8'd0, 1'b0};
                    end
                    else
                    begin
                        ent.fetching = 1'b0;
                        ent.bad      = ioerr_reg;
                        ent.waiters  = 8'd0;
                        ram_we       = 1'b1;
                        ram_wdata    = ent;
                        rq.data      = '{KIND_RESPONSE, ioerr_reg ? ST_IO_ERROR : ST_OK,
                                         slot_reg, rent.tag, rent.waiters, 1'b0};
                        if (rent.refs == 16'd0 && ioerr_reg)
                        begin
                            used_next[IDX_W'(slot_reg)]  = 1'b0;
                            avail_next[IDX_W'(slot_reg)] = 1'b0;
                            used_tot_next = used_tot_reg - CNT_W'(1);
                            rq.data.destroyed = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (!slot_ok || !used_reg[IDX_W'(slot_reg)] || rent.refs == 16'd0)
                    begin
                        rq.data = '{KIND_RESPONSE, ST_BAD_RELEASE, slot_reg, 32'd0, 8'd0, 1'b0};
                    end
                    else
                    begin
                        if (abort_reg && rent.fetching && rent.waiters != 8'd0)
                        begin
                            ent.waiters = rent.waiters - 8'd1;
                        end
                        ent.refs = rent.refs - 16'd1;
                        rq.data  = '{KIND_RESPONSE, ST_OK, slot_reg, rent.tag, ent.waiters,
                                     1'b0};
                        if (rent.refs == 16'd1)
                        begin
                            ref_tot_next = ref_tot_reg - CNT_W'(1);
                            if (!rent.fetching && rent.bad)
                            begin
                                used_next[IDX_W'(slot_reg)]  = 1'b0;
                                avail_next[IDX_W'(slot_reg)] = 1'b0;
                                used_tot_next = used_tot_reg - CNT_W'(1);
                                rq.data.destroyed = 1'b1;
                            end
                            else
                            begin
                                avail_next[IDX_W'(slot_reg)] = 1'b1;
                                ent.age  = age_reg;
                                age_next = age_reg + 32'd1;
                            end
                        end
                        ram_we    = 1'b1;
                        ram_wdata = ent;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (claim_go)
        begin
            ram_we               = 1'b1;
            ram_waddr            = claim_idx;
            used_next[claim_idx] = 1'b1;
            rq.push              = 1'b1;
            if (has_free)
            begin
                used_tot_next = used_tot_reg + CNT_W'(1);
            end
            if (claim_blank)
            begin
                ram_wdata             = '{32'd0, 16'd1, 1'b0, 1'b1, 32'd0, 8'd0};
                avail_next[claim_idx] = 1'b0;
                ref_tot_next          = ref_tot_reg + CNT_W'(1);
                rq.data = '{KIND_RESPONSE, ST_OK, SLOT_W'(claim_idx), 32'd0, 8'd0, 1'b0};
            end
            else
            begin
                ram_wdata             = '{key_reg, 16'd0, 1'b1, 1'b1, age_reg, 8'd0};
                avail_next[claim_idx] = 1'b1;
                age_next              = age_reg + 32'd1;
                rq.data = '{KIND_FETCH, ST_OK, SLOT_W'(claim_idx), key_reg, 8'd0, 1'b0};
            end
        end

        if (finish)
        begin
            rq.commit  = 1'b1;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        addr_reg     <= addr_next;
        slot_reg     <= slot_next;
        ioerr_reg    <= ioerr_next;
        abort_reg    <= abort_next;
        key_reg      <= key_next;
        lookup_reg   <= lookup_next;
        ra_phase_reg <= ra_phase_next;
        ra_i_reg     <= ra_i_next;
        scan_idx_reg <= scan_idx_next;
        scan_ci_reg  <= scan_ci_next;
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
        u_reg        <= u_next;
        cur_reg      <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_pend_reg <= 1'b0;
            best_vld_reg  <= 1'b0;
            used_reg      <= '0;
            avail_reg     <= '0;
            age_reg       <= '0;
            used_tot_reg  <= '0;
            ref_tot_reg   <= '0;
            mounted_reg   <= 1'b0;
            vsize_reg     <= '0;
            ra_cnt_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_pend_reg <= scan_pend_next;
            best_vld_reg  <= best_vld_next;
            used_reg      <= used_next;
            avail_reg     <= avail_next;
            age_reg       <= age_next;
            used_tot_reg  <= used_tot_next;
            ref_tot_reg   <= ref_tot_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MOUNTED:   mounted_reg <= cfg_wdata[0];
                    REG_VOL_SIZE:  vsize_reg   <= cfg_wdata;
                    REG_READAHEAD: ra_cnt_reg  <= cfg_wdata[3:0];
                    default:       ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire
